FILE: hw/rtl/stt_pkg.sv
package stt_pkg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_marker;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] start_offset;
        logic [15:0] end_offset;
        logic        last_of_run;
    } t_out_item;

    typedef enum logic [3:0] {
        M_IDLE     = 4'd0,
        M_SLASH    = 4'd1,
        M_COMMENT  = 4'd2,
        M_IDENT    = 4'd3,
        M_NUM_INT  = 4'd4,
        M_NUM_DOT  = 4'd5,
        M_NUM_FRAC = 4'd6,
        M_STRING   = 4'd7,
        M_PAIR     = 4'd8
    } t_mode;

    localparam logic [5:0] K_IDENT  = 6'd0;
    localparam logic [5:0] K_NUMBER = 6'd1;
    localparam logic [5:0] K_STRING = 6'd2;
    localparam logic [5:0] K_LPAREN = 6'd3;
    localparam logic [5:0] K_RPAREN = 6'd4;
    localparam logic [5:0] K_LBRACE = 6'd5;
    localparam logic [5:0] K_RBRACE = 6'd6;
    localparam logic [5:0] K_MINUS  = 6'd7;
    localparam logic [5:0] K_PLUS   = 6'd8;
    localparam logic [5:0] K_STAR   = 6'd9;
    localparam logic [5:0] K_SLASH  = 6'd10;
    localparam logic [5:0] K_ASSIGN = 6'd11;
    localparam logic [5:0] K_EQ     = 6'd12;
    localparam logic [5:0] K_BANG   = 6'd13;
    localparam logic [5:0] K_NE     = 6'd14;
    localparam logic [5:0] K_LT     = 6'd15;
    localparam logic [5:0] K_LE     = 6'd16;
    localparam logic [5:0] K_GT     = 6'd17;
    localparam logic [5:0] K_GE     = 6'd18;
    localparam logic [5:0] K_AND    = 6'd19;
    localparam logic [5:0] K_OR     = 6'd20;
    localparam logic [5:0] K_SEMI   = 6'd21;
    localparam logic [5:0] K_COLON  = 6'd22;
    localparam logic [5:0] K_COMMA  = 6'd23;
    localparam logic [5:0] K_DOT    = 6'd24;
    localparam logic [5:0] K_KW0    = 6'd25;
    localparam logic [5:0] K_ERROR  = 6'd37;
    localparam logic [5:0] K_END    = 6'd38;

    localparam int MAX_TOK = 4;

    // one token slot of the per-byte result set
    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] s;
        logic [15:0] e;
    } t_tok;

    // keyword text, byte i at bits 8i+7..8i, zero padded
    function automatic logic [63:0] kw_text(input logic [3:0] k);
        case (k)
            4'd0:    kw_text = 64'h0000_0074_736E_6F63; // const
            4'd1:    kw_text = 64'h0000_0000_6573_6C65; // else
            4'd2:    kw_text = 64'h0000_0000_6D75_6E65; // enum
            4'd3:    kw_text = 64'h0000_0065_736C_6166; // false
            4'd4:    kw_text = 64'h0000_0000_0000_6E66; // fn
            4'd5:    kw_text = 64'h006E_6769_6572_6F66; // foreign
            4'd6:    kw_text = 64'h0000_0000_0000_6669; // if
            4'd7:    kw_text = 64'h0000_0000_0074_656C; // let
            4'd8:    kw_text = 64'h0000_6E72_7574_6572; // return
            4'd9:    kw_text = 64'h0000_7463_7572_7473; // struct
            4'd10:   kw_text = 64'h0000_0000_6575_7274; // true
            4'd11:   kw_text = 64'h0000_0065_6C69_6877; // while
            default: kw_text = 64'h0;
        endcase
    endfunction

    function automatic logic [3:0] kw_len(input logic [3:0] k);
        case (k)
            4'd0, 4'd3, 4'd11:        kw_len = 4'd5;
            4'd1, 4'd2, 4'd10:        kw_len = 4'd4;
            4'd4, 4'd6:               kw_len = 4'd2;
            4'd5:                     kw_len = 4'd7;
            4'd7:                     kw_len = 4'd3;
            4'd8, 4'd9:               kw_len = 4'd6;
            default:                  kw_len = 4'd0;
        endcase
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [5:0] pair_kind(input logic [7:0] h, input logic paired);
        case (h)
            8'h3D:   pair_kind = paired ? K_EQ : K_ASSIGN;
            8'h21:   pair_kind = paired ? K_NE : K_BANG;
            8'h3C:   pair_kind = paired ? K_LE : K_LT;
            8'h3E:   pair_kind = paired ? K_GE : K_GT;
            8'h26:   pair_kind = paired ? K_AND : K_ERROR;
            default: pair_kind = paired ? K_OR : K_ERROR;
        endcase
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] b);
        case (b)
            8'h28:   single_kind = K_LPAREN;
            8'h29:   single_kind = K_RPAREN;
            8'h7B:   single_kind = K_LBRACE;
            8'h7D:   single_kind = K_RBRACE;
            8'h2D:   single_kind = K_MINUS;
            8'h2B:   single_kind = K_PLUS;
            8'h2A:   single_kind = K_STAR;
            8'h3B:   single_kind = K_SEMI;
            8'h3A:   single_kind = K_COLON;
            8'h2C:   single_kind = K_COMMA;
            8'h2E:   single_kind = K_DOT;
            default: single_kind = K_ERROR;
        endcase
    endfunction

endpackage

FILE: hw/rtl/source_text_tokenizer_unit.sv
// Tokenizer: one source byte per transaction, up to three tokens per byte.
// Tokens of a byte are registered and appear the cycle after it is accepted.
// Throughput: one byte per cycle when each byte yields at most one token and i_stall is low;
// a byte that yields several tokens holds the output register until its last token leaves.
// Reset (synchronous, active low) returns the scanner to idle at offset zero.
module source_text_tokenizer_unit
    import stt_pkg::*;
#(
    parameter int OFFSET_BITS   = 16,
    parameter int KEYWORD_CHARS = 7
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    t_mode                      r_mode, n_mode;
    logic [OFFSET_BITS-1:0]     r_off, n_off, r_beg, n_beg;
    logic [7:0]                 r_held, n_held;
    logic [8*KEYWORD_CHARS-1:0] r_pre, n_pre;
    logic [3:0]                 r_len, n_len;

    logic       accept, free;
    logic [5:0] wkind;
    logic [2:0] cnt;
    t_tok       tok [MAX_TOK];

    assign o_stall = !free;
    assign accept  = i_valid && free;

    stt_kw_match #(.KEYWORD_CHARS(KEYWORD_CHARS)) u_kw (
        .i_prefix (r_pre),
        .i_len    (r_len),
        .o_kind   (wkind)
    );

    // next-state and token generation for one byte
    always_comb begin
        logic [7:0]             b;
        logic [OFFSET_BITS-1:0] pos, nxt, bef;
        logic                   take;
        logic [15:0]            p16, n16, b16, t16;
        b    = i_item.text_byte;
        pos  = r_off;
        nxt  = (pos < OFF_MAX) ? pos + 1'b1 : OFF_MAX;
        bef  = (pos != '0) ? pos - 1'b1 : '0;
        p16  = 16'(pos);
        n16  = 16'(nxt);
        b16  = 16'(bef);
        t16  = 16'(r_beg);
        n_mode = r_mode; n_off = r_off; n_beg = r_beg;
        n_held = r_held; n_pre = r_pre; n_len = r_len;
        cnt  = 3'd0;
        take = 1'b0;
        for (int i = 0; i < MAX_TOK; i++) tok[i] = '0;

        if (i_item.end_marker) begin
            // flush pending token, then end token
            case (r_mode)
                M_SLASH:  begin tok[0] = '{K_SLASH, t16, p16}; cnt = 3'd1; end
                M_IDENT:  begin tok[0] = '{wkind, t16, p16}; cnt = 3'd1; end
                M_NUM_INT, M_NUM_FRAC: begin
                    tok[0] = '{K_NUMBER, t16, p16}; cnt = 3'd1;
                end
                M_NUM_DOT: begin
                    tok[0] = '{K_NUMBER, t16, b16};
                    tok[1] = '{K_DOT, b16, p16}; cnt = 3'd2;
                end
                M_STRING: begin tok[0] = '{K_ERROR, t16, p16}; cnt = 3'd1; end
                M_PAIR: begin
                    tok[0] = '{pair_kind(r_held, 1'b0), t16, p16}; cnt = 3'd1;
                end
                default: ;
            endcase
            tok[cnt[1:0]] = '{K_END, p16, p16};
            cnt    = cnt + 3'd1;
            n_mode = M_IDLE; n_off = '0; n_beg = '0;
            n_held = '0; n_pre = '0; n_len = '0;
        end else begin
            case (r_mode)
                M_IDLE: take = 1'b1;
                M_SLASH: begin
                    if (b == 8'h2F) n_mode = M_COMMENT;
                    else begin tok[0] = '{K_SLASH, t16, p16}; cnt = 3'd1; take = 1'b1; end
                end
                M_COMMENT: if (b == 8'h0A) take = 1'b1;
                M_IDENT: begin
                    if (is_alpha(b) || is_digit(b)) begin
                        for (int i = 0; i < KEYWORD_CHARS; i++)
                            if (r_len == 4'(i)) n_pre[8*i +: 8] = r_pre[8*i +: 8] | b;
                        if (r_len != 4'd15) n_len = r_len + 4'd1;
                    end else begin
                        tok[0] = '{wkind, t16, p16}; cnt = 3'd1; take = 1'b1;
                    end
                end
                M_NUM_INT: begin
                    if (b == 8'h2E) n_mode = M_NUM_DOT;
                    else if (!is_digit(b)) begin
                        tok[0] = '{K_NUMBER, t16, p16}; cnt = 3'd1; take = 1'b1;
                    end
                end
                M_NUM_DOT: begin
                    if (is_digit(b)) n_mode = M_NUM_FRAC;
                    else begin
                        tok[0] = '{K_NUMBER, t16, b16};
                        tok[1] = '{K_DOT, b16, p16}; cnt = 3'd2; take = 1'b1;
                    end
                end
                M_NUM_FRAC: begin
                    if (!is_digit(b)) begin
                        tok[0] = '{K_NUMBER, t16, p16}; cnt = 3'd1; take = 1'b1;
                    end
                end
                M_STRING: begin
                    if (b == 8'h22) begin
                        tok[0] = '{K_STRING, t16, n16}; cnt = 3'd1; n_mode = M_IDLE;
                    end else if (b == 8'h0A) begin
                        tok[0] = '{K_ERROR, t16, p16}; cnt = 3'd1; take = 1'b1;
                    end
                end
                M_PAIR: begin
                    if (b == ((r_held == 8'h26 || r_held == 8'h7C) ? r_held : 8'h3D)) begin
                        tok[0] = '{pair_kind(r_held, 1'b1), t16, n16}; cnt = 3'd1;
                        n_mode = M_IDLE;
                    end else begin
                        tok[0] = '{pair_kind(r_held, 1'b0), t16, p16}; cnt = 3'd1;
                        take = 1'b1;
                    end
                end
                default: take = 1'b1;
            endcase
            // start of a new token from idle
            if (take) begin
                n_mode = M_IDLE;
                n_beg  = pos;
                if (b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A) begin
                    n_mode = M_IDLE;
                end else if (b == 8'h2F) begin
                    n_mode = M_SLASH;
                end else if (is_alpha(b)) begin
                    n_pre        = '0;
                    n_pre[7:0]   = b;
                    n_len        = 4'd1;
                    n_mode       = M_IDENT;
                end else if (is_digit(b)) begin
                    n_mode = M_NUM_INT;
                end else if (b == 8'h22) begin
                    n_mode = M_STRING;
                end else if (b == 8'h3D || b == 8'h21 || b == 8'h3C || b == 8'h3E
                        || b == 8'h26 || b == 8'h7C) begin
                    n_held = b;
                    n_mode = M_PAIR;
                end else begin
                    tok[cnt[1:0]] = '{single_kind(b), p16, n16};
                    cnt = cnt + 3'd1;
                end
            end
            n_off = nxt;
        end
    end

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_off  <= '0;
            r_beg  <= '0;
            r_held <= '0;
            r_pre  <= '0;
            r_len  <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_off  <= n_off;
            r_beg  <= n_beg;
            r_held <= n_held;
            r_pre  <= n_pre;
            r_len  <= n_len;
        end
    end

    stt_out_queue u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_cnt   (cnt),
        .i_tok   (tok),
        .o_free  (free),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );
endmodule

FILE: hw/rtl/stt_kw_match.sv
module stt_kw_match
    import stt_pkg::*;
#(
    parameter int KEYWORD_CHARS = 7
) (
    input  logic [8*KEYWORD_CHARS-1:0] i_prefix,
    input  logic [3:0]                 i_len,
    output logic [5:0]                 o_kind
);
    // twelve parallel compares against the stored identifier prefix
    always_comb begin
        logic [63:0] pre;
        pre    = 64'(i_prefix);
        o_kind = K_IDENT;
        for (int k = 11; k >= 0; k--) begin
            if (i_len == kw_len(4'(k)) && kw_len(4'(k)) <= 4'(KEYWORD_CHARS)
                    && pre == kw_text(4'(k))) begin
                o_kind = K_KW0 + 6'(k);
            end
        end
    end
endmodule

FILE: hw/rtl/stt_out_queue.sv
module stt_out_queue
    import stt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  logic [2:0] i_cnt,
    input  t_tok      i_tok [MAX_TOK],
    output logic      o_free,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);
    logic [2:0] r_cnt, r_idx;
    t_tok       r_tok [MAX_TOK];
    logic       busy;

    assign busy    = r_cnt != 3'd0;
    assign o_valid = busy;
    // free next edge when empty or last token leaves now
    assign o_free  = !busy || (!i_stall && r_idx + 3'd1 == r_cnt);

    always_comb begin
        o_item.token_kind   = r_tok[r_idx[1:0]].kind;
        o_item.start_offset = r_tok[r_idx[1:0]].s;
        o_item.end_offset   = r_tok[r_idx[1:0]].e;
        o_item.last_of_run  = r_idx + 3'd1 == r_cnt;
    end

    // token set register, drained one transaction per cycle while i_stall is low
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_idx <= 3'd0;
        end else if (i_load) begin
            r_cnt <= i_cnt;
            r_idx <= 3'd0;
            r_tok <= i_tok;
        end else if (busy && !i_stall) begin
            if (r_idx + 3'd1 == r_cnt) begin
                r_cnt <= 3'd0;
                r_idx <= 3'd0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end
endmodule
